[rtl/core/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared constants, codes and types of the pulse train table sequencer.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int LenW       = 5;
  localparam int MaxCurW    = 12;
  localparam int AmpW       = 16;
  localparam int DurW       = 16;
  localparam int ElapsedW   = 17;
  localparam int CurW       = 13;
  localparam int StepW      = 4;
  localparam int EntryW     = 4;
  localparam int OpW        = 2;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  localparam logic [LenW-1:0]    SeqLenReset = 5'd1;
  localparam logic [MaxCurW-1:0] MaxCurReset = 12'd2000;

  // operation codes
  localparam logic [OpW-1:0] OpTick    = 2'd0;
  localparam logic [OpW-1:0] OpRestart = 2'd1;
  localparam logic [OpW-1:0] OpLoad    = 2'd2;

  // register indexes (paddr[2])
  localparam logic RegSeqLen = 1'b0;
  localparam logic RegMaxCur = 1'b1;

  typedef struct packed {
    logic [LenW-1:0]    len_eff;
    logic [MaxCurW-1:0] clamp_limit;
  } cfg_t;

  typedef struct packed {
    logic                   en;
    logic [IdxW-1:0]        addr;
    logic signed [AmpW-1:0] amp;
    logic [DurW-1:0]        dur;
  } tab_wr_t;

  typedef struct packed {
    logic [IdxW-1:0] dur_addr;
    logic [IdxW-1:0] amp_addr;
  } tab_addr_t;

  typedef struct packed {
    logic [DurW-1:0]        dur_at;
    logic signed [AmpW-1:0] amp_at;
    logic [DurW-1:0]        dur0;
    logic [DurW-1:0]        dur1;
  } tab_rd_t;

  typedef struct packed {
    logic                   emit;
    logic signed [CurW-1:0] current;
    logic [StepW-1:0]       step;
  } res_t;

endpackage

[rtl/core/pulse_train_table_sequencer_core.sv]
// ----------------------------------------------------------------------------
// pulse_train_table_sequencer_core
// Plays a repeating amplitude/duration table, one step per tick word.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_stall    operation, entry_index,
//                                                  entry_amplitude, entry_duration
//   result   out        result_valid / result_stall current_ua, step_index
//   config   in/out     APB psel/penable/pready    paddr, pwdata, prdata
//
// One item word per cycle sustained while the result is not stalled; a tick
// that ends a step passes from the input register through the combinational
// step logic into the result register. Synchronous reset clears the sequencer
// position, the count and the valid flags of both registers; table contents
// are not reset. A stalled result holds in the result register while one
// more item word waits in the input register, after which item_stall rises.
// ----------------------------------------------------------------------------
module pulse_train_table_sequencer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptts_pkg::AddrW-1:0]        paddr,
  input  logic [ptts_pkg::DataW-1:0]        pwdata,
  output logic [ptts_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [ptts_pkg::OpW-1:0]          operation,
  input  logic [ptts_pkg::EntryW-1:0]       entry_index,
  input  logic signed [ptts_pkg::AmpW-1:0]  entry_amplitude,
  input  logic [ptts_pkg::DurW-1:0]         entry_duration,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [ptts_pkg::CurW-1:0]  current_ua,
  output logic [ptts_pkg::StepW-1:0]        step_index
);

  ptts_pkg::cfg_t      cfg;
  ptts_pkg::tab_wr_t   tab_wr;
  ptts_pkg::tab_addr_t tab_addr;
  ptts_pkg::tab_rd_t   tab_rd;
  ptts_pkg::res_t      res;

  logic                             s1_valid;
  logic [ptts_pkg::OpW-1:0]         s1_op;
  logic [ptts_pkg::EntryW-1:0]      s1_index;
  logic signed [ptts_pkg::AmpW-1:0] s1_amp;
  logic [ptts_pkg::DurW-1:0]        s1_dur;
  logic                             advance;
  logic                             fire;

  assign advance    = !result_valid || !result_stall;
  assign fire       = s1_valid && advance;
  assign item_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_op    <= operation;
      s1_index <= entry_index;
      s1_amp   <= entry_amplitude;
      s1_dur   <= entry_duration;
    end
  end

  ptts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptts_table u_table (
    .clk  (clk),
    .wr   (tab_wr),
    .addr (tab_addr),
    .rd   (tab_rd)
  );

  ptts_step u_step (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .op              (s1_op),
    .entry_index     (s1_index),
    .entry_amplitude (s1_amp),
    .entry_duration  (s1_dur),
    .cfg             (cfg),
    .rd              (tab_rd),
    .addr            (tab_addr),
    .wr              (tab_wr),
    .res             (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      current_ua <= res.current;
      step_index <= res.step;
    end
  end

  logic signed [ptts_pkg::CurW:0] cur_x;
  logic signed [ptts_pkg::CurW:0] chk_pos;
  logic signed [ptts_pkg::CurW:0] chk_neg;

  always_comb begin
    cur_x   = (ptts_pkg::CurW+1)'(current_ua);
    chk_pos = $signed((ptts_pkg::CurW+1)'(cfg.clamp_limit));
    chk_neg = -chk_pos;
  end

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cur_x <= chk_pos) && (cur_x >= chk_neg))
    else $error("emitted current outside clamp");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(step_index) < 32'(cfg.len_eff)))
    else $error("step index beyond sequence length");

  a_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && (s1_op == ptts_pkg::OpTick)))
    else $error("result without a tick word");

  a_no_load_emit: assert property (@(posedge clk) disable iff (rst)
    tab_wr.en |-> !res.emit)
    else $error("table load produced a result");

endmodule

[rtl/core/ptts_cfg.sv]
// ----------------------------------------------------------------------------
// ptts_cfg
// APB register file: sequence length and clamp magnitude.
// ----------------------------------------------------------------------------
module ptts_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptts_pkg::AddrW-1:0]   paddr,
  input  logic [ptts_pkg::DataW-1:0]   pwdata,
  output logic [ptts_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output ptts_pkg::cfg_t               cfg
);

  logic [ptts_pkg::LenW-1:0]    seq_len;
  logic [ptts_pkg::MaxCurW-1:0] clamp_limit;
  logic                         wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len     <= ptts_pkg::SeqLenReset;
      clamp_limit <= ptts_pkg::MaxCurReset;
    end else if (wr) begin
      unique case (paddr[2])
        ptts_pkg::RegSeqLen: seq_len     <= pwdata[ptts_pkg::LenW-1:0];
        ptts_pkg::RegMaxCur: clamp_limit <= pwdata[ptts_pkg::MaxCurW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ptts_pkg::RegSeqLen: prdata = ptts_pkg::DataW'(seq_len);
      ptts_pkg::RegMaxCur: prdata = ptts_pkg::DataW'(clamp_limit);
      default:             prdata = '0;
    endcase
  end

  // zero plays as one entry, anything past the table plays the whole table
  always_comb begin
    if (seq_len == '0) begin
      cfg.len_eff = ptts_pkg::LenW'(1);
    end else if (32'(seq_len) > ptts_pkg::MaxEntries) begin
      cfg.len_eff = ptts_pkg::LenW'(ptts_pkg::MaxEntries);
    end else begin
      cfg.len_eff = seq_len;
    end
    cfg.clamp_limit = clamp_limit;
  end

endmodule

[rtl/core/ptts_table.sv]
// ----------------------------------------------------------------------------
// ptts_table
// Amplitude and duration table, one write port, flop storage.
// ----------------------------------------------------------------------------
module ptts_table (
  input  logic                clk,
  input  ptts_pkg::tab_wr_t   wr,
  input  ptts_pkg::tab_addr_t addr,
  output ptts_pkg::tab_rd_t   rd
);

  logic signed [ptts_pkg::AmpW-1:0] amp_tab [ptts_pkg::MaxEntries];
  logic [ptts_pkg::DurW-1:0]        dur_tab [ptts_pkg::MaxEntries];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      amp_tab[wr.addr] <= wr.amp;
      dur_tab[wr.addr] <= wr.dur;
    end
  end

  always_comb begin
    rd.dur_at = dur_tab[addr.dur_addr];
    rd.amp_at = amp_tab[addr.amp_addr];
    rd.dur0   = dur_tab[0];
    rd.dur1   = dur_tab[1];
  end

endmodule

[rtl/core/ptts_step.sv]
// ----------------------------------------------------------------------------
// ptts_step
// Sequencer state and the per-word step: count, compare, advance, clamp.
// ----------------------------------------------------------------------------
module ptts_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [ptts_pkg::OpW-1:0]          op,
  input  logic [ptts_pkg::EntryW-1:0]       entry_index,
  input  logic signed [ptts_pkg::AmpW-1:0]  entry_amplitude,
  input  logic [ptts_pkg::DurW-1:0]         entry_duration,
  input  ptts_pkg::cfg_t                    cfg,
  input  ptts_pkg::tab_rd_t                 rd,
  output ptts_pkg::tab_addr_t               addr,
  output ptts_pkg::tab_wr_t                 wr,
  output ptts_pkg::res_t                    res
);

  logic [ptts_pkg::IdxW-1:0]     active_index;
  logic [ptts_pkg::ElapsedW-1:0] elapsed;

  logic [ptts_pkg::ElapsedW-1:0]     elapsed_next;
  logic [ptts_pkg::IdxW:0]           idx_sum;
  logic [ptts_pkg::IdxW-1:0]         index_next;
  logic                              use_dur0;
  logic [ptts_pkg::DurW-1:0]         dur;
  logic                              hit;
  logic signed [ptts_pkg::AmpW:0]    amp_x;
  logic signed [ptts_pkg::AmpW:0]    lim_pos;
  logic signed [ptts_pkg::AmpW:0]    lim_neg;
  logic signed [ptts_pkg::AmpW:0]    amp_clamped;

  always_comb begin
    // saturate the count
    elapsed_next = (elapsed < ptts_pkg::ElapsedMax) ? elapsed + 1'b1 : elapsed;

    // single-duration mode, one-entry sequence, or index left past a shrunk length
    use_dur0 = (cfg.len_eff == ptts_pkg::LenW'(1)) || (rd.dur1 == '0) ||
               (32'(active_index) >= 32'(cfg.len_eff));
    dur      = use_dur0 ? rd.dur0 : rd.dur_at;
    hit      = elapsed_next >= ptts_pkg::ElapsedW'(dur);

    idx_sum    = (ptts_pkg::IdxW+1)'(active_index) + 1'b1;
    index_next = (32'(idx_sum) >= 32'(cfg.len_eff)) ? '0 : ptts_pkg::IdxW'(idx_sum);

    addr.dur_addr = active_index;
    addr.amp_addr = index_next;

    amp_x   = (ptts_pkg::AmpW+1)'(rd.amp_at);
    lim_pos = $signed((ptts_pkg::AmpW+1)'(cfg.clamp_limit));
    lim_neg = -lim_pos;
    if (amp_x > lim_pos) begin
      amp_clamped = lim_pos;
    end else if (amp_x < lim_neg) begin
      amp_clamped = lim_neg;
    end else begin
      amp_clamped = amp_x;
    end

    res.emit    = fire && (op == ptts_pkg::OpTick) && hit;
    res.current = ptts_pkg::CurW'(amp_clamped);
    res.step    = ptts_pkg::StepW'(index_next);

    // drop loads aimed past the table
    wr.en   = fire && (op == ptts_pkg::OpLoad) &&
              (32'(entry_index) < ptts_pkg::MaxEntries);
    wr.addr = ptts_pkg::IdxW'(entry_index);
    wr.amp  = entry_amplitude;
    wr.dur  = entry_duration;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_index <= '0;
      elapsed      <= '0;
    end else if (fire) begin
      unique case (op)
        ptts_pkg::OpTick: begin
          if (hit) begin
            active_index <= index_next;
            elapsed      <= '0;
          end else begin
            elapsed      <= elapsed_next;
          end
        end
        ptts_pkg::OpRestart: begin
          active_index <= '0;
          elapsed      <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
